// ===== sv/gdtq_pkg.sv =====
// Shared types and helpers for the grouped deadline timer queue.
// Used by gdtq_cell and grouped_deadline_timer_queue; depends on nothing.
package gdtq_pkg;

  localparam int TIME_W = 48;
  localparam int PER_W  = 32;
  // Widest slot and group indexes the block supports.
  localparam int SLOT_W = 6;
  localparam int GRP_W  = 4;

  localparam logic [1:0] OP_START_ABS = 2'd0;
  localparam logic [1:0] OP_START_REL = 2'd1;
  localparam logic [1:0] OP_STOP      = 2'd2;
  localparam logic [1:0] OP_TICK      = 2'd3;

  localparam logic KIND_FIRED  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SCAN,
    ST_EVAL
  } state_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_ARM,
    CMD_STOP,
    CMD_SNAP,
    CMD_FIRE
  } cmd_kind_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    cmd_kind_t           kind;
    logic [SLOT_W-1:0]   slot;
    logic [GRP_W-1:0]    group;
    logic [TIME_W-1:0]   deadline;
    logic [PER_W-1:0]    period;
    logic [TIME_W-1:0]   now;
  } cmd_t;

  // Record handed from cell to cell during a scan.
  typedef struct packed {
    logic                found;
    logic [SLOT_W-1:0]   slot;
    logic [TIME_W-1:0]   deadline;
    logic [PER_W-1:0]    period;
    logic                min_found;
    logic [TIME_W-1:0]   min_dl;
  } cand_t;

  function automatic logic [TIME_W-1:0] sat_add48(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
    logic [TIME_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  endfunction

endpackage

// ===== sv/gdtq_cell.sv =====
// One timer slot of the queue: deadline, period, group, flags and age row.
// Passes the scan record on to its neighbor every cycle. Uses gdtq_pkg.
module gdtq_cell #(
  parameter int SLOTS   = 16,
  parameter int CELL_ID = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  gdtq_pkg::cmd_t              cmd,
  input  logic [gdtq_pkg::GRP_W-1:0]  scan_group,
  input  gdtq_pkg::cand_t             cand_in,
  output gdtq_pkg::cand_t             cand_out
);

  localparam int IDX_W = $clog2(SLOTS);

  logic                          active;
  logic                          elig;
  logic [gdtq_pkg::TIME_W-1:0]   deadline;
  logic [gdtq_pkg::PER_W-1:0]    period;
  logic [gdtq_pkg::GRP_W-1:0]    group;
  // older[j] is set when this slot was armed before slot j.
  logic [SLOTS-1:0]              older;

  logic                          is_me;
  logic                          self_wins;
  logic                          self_min;
  logic [IDX_W-1:0]              cmd_idx;
  logic [IDX_W-1:0]              cand_idx;
  gdtq_pkg::cand_t               cand_next;

  assign is_me    = cmd.slot == gdtq_pkg::SLOT_W'(CELL_ID);
  assign cmd_idx  = cmd.slot[IDX_W-1:0];
  assign cand_idx = cand_in.slot[IDX_W-1:0];

  always_comb begin
    self_wins = elig && (group == scan_group) &&
                (!cand_in.found || (deadline > cand_in.deadline) ||
                 ((deadline == cand_in.deadline) && older[cand_idx]));
    self_min  = active && (!cand_in.min_found || (deadline < cand_in.min_dl));
    cand_next = cand_in;
    if (self_wins) begin
      cand_next.found    = 1'b1;
      cand_next.slot     = gdtq_pkg::SLOT_W'(CELL_ID);
      cand_next.deadline = deadline;
      cand_next.period   = period;
    end
    if (self_min) begin
      cand_next.min_found = 1'b1;
      cand_next.min_dl    = deadline;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out <= '0;
    end else begin
      cand_out <= cand_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      elig   <= 1'b0;
    end else begin
      unique case (cmd.kind)
        gdtq_pkg::CMD_ARM: begin
          if (is_me) begin
            active   <= 1'b1;
            elig     <= 1'b0;
            deadline <= cmd.deadline;
            period   <= cmd.period;
            group    <= cmd.group;
            older    <= '0;
          end else begin
            older[cmd_idx] <= 1'b1;
          end
        end
        gdtq_pkg::CMD_STOP: begin
          if (is_me) begin
            active <= 1'b0;
          end
        end
        gdtq_pkg::CMD_SNAP: begin
          elig <= active && (deadline <= cmd.now);
        end
        gdtq_pkg::CMD_FIRE: begin
          if (is_me) begin
            elig <= 1'b0;
            if (period == '0) begin
              active <= 1'b0;
            end else begin
              deadline <= cmd.deadline;
              older    <= '0;
            end
          end else if (cmd.period != '0) begin
            // A periodic slot that fires becomes the youngest one.
            older[cmd_idx] <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/grouped_deadline_timer_queue.sv =====
// Top level of the grouped deadline timer queue: controller and row of slot cells.
// Uses gdtq_pkg and gdtq_cell.
//
// Input beats carry an opcode (start absolute, start relative, stop, tick)
// with slot, group, time, period and current time. Each beat yields zero or
// more fired-slot beats and then one report beat (last high) with the
// earliest pending deadline. in_stall is high from acceptance until the
// report has been loaded into the output register.
// Every search runs a record down the row of SLOTS cells, one cell per
// cycle, and each search is followed by its evaluation.
// A start or stop needs a single search before its report. A tick needs
// one search per slot that fires and one per group that ends.
// When out_stall is high the output register holds its beat and the
// controller waits before loading the next one.
// Reset clears all active flags and the controller; no slot is pending.
module grouped_deadline_timer_queue #(
  parameter int SLOTS  = 16,
  parameter int GROUPS = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   opcode,
  input  logic [3:0]   slot_index,
  input  logic [1:0]   group_index,
  input  logic [47:0]  time_value,
  input  logic [31:0]  period_value,
  input  logic [47:0]  now_time,
  output logic         out_valid,
  input  logic         out_stall,
  output logic         kind,
  output logic [3:0]   fired_slot,
  output logic [1:0]   fired_group,
  output logic         overrun,
  output logic [47:0]  next_deadline,
  output logic         deadline_valid,
  output logic         last
);

  localparam int CNT_W = $clog2(SLOTS);
  localparam int GW    = gdtq_pkg::GRP_W;

  gdtq_pkg::state_t              state;
  gdtq_pkg::state_t              state_next;
  logic [CNT_W-1:0]              cnt;
  logic [1:0]                    op;
  logic [3:0]                    slot_q;
  logic [GW-1:0]                 grp_q;
  logic [47:0]                   tv_q;
  logic [31:0]                   pv_q;
  logic [47:0]                   now_q;
  logic [GW-1:0]                 cur_group;

  gdtq_pkg::cmd_t                cmd;
  gdtq_pkg::cand_t               chain [SLOTS+1];
  gdtq_pkg::cand_t               res;

  logic                          in_accept;
  logic                          out_free;
  logic                          load_fire;
  logic                          load_report;
  logic                          next_group;
  logic                          scan_done;
  logic [47:0]                   reload_dl;
  logic                          reload_late;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = state != gdtq_pkg::ST_IDLE;
  assign out_free  = !out_valid || !out_stall;
  assign scan_done = cnt == CNT_W'(SLOTS - 1);
  assign res       = chain[SLOTS];
  assign chain[0]  = '0;

  assign reload_dl   = gdtq_pkg::sat_add48(res.deadline, {16'b0, res.period});
  assign reload_late = reload_dl < now_q;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      gdtq_pkg::ST_IDLE:  if (in_accept) state_next = gdtq_pkg::ST_APPLY;
      gdtq_pkg::ST_APPLY: state_next = gdtq_pkg::ST_SCAN;
      gdtq_pkg::ST_SCAN:  if (scan_done) state_next = gdtq_pkg::ST_EVAL;
      gdtq_pkg::ST_EVAL: begin
        if (next_group || load_fire) begin
          state_next = gdtq_pkg::ST_SCAN;
        end else if (load_report) begin
          state_next = gdtq_pkg::ST_IDLE;
        end
      end
      default: state_next = gdtq_pkg::ST_IDLE;
    endcase
  end

  // Cell commands and output loads.
  always_comb begin
    cmd          = '0;
    cmd.kind     = gdtq_pkg::CMD_NONE;
    cmd.slot     = gdtq_pkg::SLOT_W'(slot_q);
    cmd.group    = grp_q;
    cmd.now      = now_q;
    cmd.deadline = (op == gdtq_pkg::OP_START_REL) ? gdtq_pkg::sat_add48(now_q, tv_q) : tv_q;
    cmd.period   = pv_q;
    load_fire    = 1'b0;
    load_report  = 1'b0;
    next_group   = 1'b0;
    unique case (state)
      gdtq_pkg::ST_APPLY: begin
        if (op == gdtq_pkg::OP_TICK) begin
          cmd.kind = gdtq_pkg::CMD_SNAP;
        end else if (32'(slot_q) < SLOTS) begin
          cmd.kind = (op == gdtq_pkg::OP_STOP) ? gdtq_pkg::CMD_STOP : gdtq_pkg::CMD_ARM;
        end
      end
      gdtq_pkg::ST_EVAL: begin
        if (res.found) begin
          if (out_free) begin
            load_fire    = 1'b1;
            cmd.kind     = gdtq_pkg::CMD_FIRE;
            cmd.slot     = res.slot;
            cmd.deadline = reload_dl;
            cmd.period   = res.period;
          end
        end else if (op == gdtq_pkg::OP_TICK && cur_group != '0) begin
          next_group = 1'b1;
        end else if (out_free) begin
          load_report = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gdtq_pkg::ST_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      if (state == gdtq_pkg::ST_SCAN) begin
        cnt <= scan_done ? '0 : cnt + 1'b1;
      end
      if (load_fire || load_report) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op     <= opcode;
      slot_q <= slot_index;
      grp_q  <= (32'(group_index) < GROUPS) ? GW'(group_index) : '0;
      tv_q   <= time_value;
      pv_q   <= period_value;
      now_q  <= now_time;
    end
    if (state == gdtq_pkg::ST_APPLY) begin
      cur_group <= GW'(GROUPS - 1);
    end else if (next_group) begin
      cur_group <= cur_group - 1'b1;
    end
    if (load_fire) begin
      kind           <= gdtq_pkg::KIND_FIRED;
      fired_slot     <= 4'(res.slot);
      fired_group    <= 2'(cur_group);
      overrun        <= (res.period != '0) && reload_late;
      next_deadline  <= '0;
      deadline_valid <= 1'b0;
      last           <= 1'b0;
    end else if (load_report) begin
      kind           <= gdtq_pkg::KIND_REPORT;
      fired_slot     <= '0;
      fired_group    <= '0;
      overrun        <= 1'b0;
      next_deadline  <= res.min_found ? res.min_dl : '0;
      deadline_valid <= res.min_found;
      last           <= 1'b1;
    end
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    gdtq_cell #(
      .SLOTS   (SLOTS),
      .CELL_ID (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .scan_group (cur_group),
      .cand_in    (chain[i]),
      .cand_out   (chain[i+1])
    );
  end

  a_report_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (kind == gdtq_pkg::KIND_REPORT)))
    else $error("last and kind disagree");

  a_fired_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == gdtq_pkg::KIND_FIRED) |-> (!deadline_valid && next_deadline == '0))
    else $error("fired beat carries a deadline");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second beat accepted while busy");

  a_report_frees: assert property (@(posedge clk) disable iff (rst)
    load_report |=> !in_stall)
    else $error("report loaded but input still stalled");

endmodule
